### sv/apce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apce_pkg
// Types, codes and helpers shared by the audio processor command encoder.
// ----------------------------------------------------------------------------
package apce_pkg;

   localparam int MAX_RUN     = 6;
   localparam int RUN_IDX_W   = $clog2(MAX_RUN);
   localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   // event kinds
   localparam logic [3:0] KIND_RESET    = 4'd0;
   localparam logic [3:0] KIND_VOLUME   = 4'd1;
   localparam logic [3:0] KIND_BASS     = 4'd2;
   localparam logic [3:0] KIND_MIDDLE   = 4'd3;
   localparam logic [3:0] KIND_TREBLE   = 4'd4;
   localparam logic [3:0] KIND_FADER    = 4'd5;
   localparam logic [3:0] KIND_BALANCE  = 4'd6;
   localparam logic [3:0] KIND_CENTER   = 4'd7;
   localparam logic [3:0] KIND_SUB      = 4'd8;
   localparam logic [3:0] KIND_GAIN     = 4'd9;
   localparam logic [3:0] KIND_INPUT    = 4'd10;
   localparam logic [3:0] KIND_MUTE     = 4'd11;
   localparam logic [3:0] KIND_EFFECT   = 4'd12;
   localparam logic [3:0] KIND_BYPASS   = 4'd13;
   localparam logic [3:0] KIND_SURROUND = 4'd14;

   // chip select
   localparam logic CHIP_MAIN  = 1'b0;
   localparam logic CHIP_MIXER = 1'b1;

   // command byte constants
   localparam logic [7:0] CMD_RESET_A   = 8'hFF;
   localparam logic [7:0] CMD_RESET_B   = 8'hC7;
   localparam logic [7:0] CMD_RESET_MIX = 8'hFE;
   localparam logic [7:0] CMD_FUNCTION  = 8'h70;
   localparam logic [7:0] FN_MUTE       = 8'h08;
   localparam logic [7:0] FN_EFFECT_OFF = 8'h04;
   localparam logic [7:0] FN_BYPASS     = 8'h02;
   localparam logic [7:0] CMD_GAIN      = 8'h90;
   localparam logic [7:0] CMD_UNITS     = 8'hD0;
   localparam logic [7:0] CMD_TENS      = 8'hE0;
   localparam logic [7:0] CMD_INPUT     = 8'hC0;
   localparam logic [7:0] CMD_SURROUND  = 8'hD0;
   localparam logic [3:0] TONE_NIB_OFS  = 4'd7;
   localparam logic [3:0] INPUT_BASE    = 4'd11;
   localparam logic [3:0] TRIM_FL       = 4'h1;
   localparam logic [3:0] TRIM_FR       = 4'h2;
   localparam logic [3:0] TRIM_CT       = 4'h3;
   localparam logic [3:0] TRIM_RL       = 4'h4;
   localparam logic [3:0] TRIM_RR       = 4'h5;
   localparam logic [3:0] TRIM_SB       = 4'h6;

   typedef struct packed {
      logic [3:0]        kind;
      logic signed [7:0] setting;
   } req_type;

   typedef struct packed {
      logic       chip;
      logic [7:0] cmd_byte;
      logic       starts_transfer;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       chip;
      logic [7:0] cmd_byte;
      logic       starts_transfer;
   } slot_type;

   // one event's whole run of bytes
   typedef struct packed {
      logic [RUN_CNT_W-1:0]     count;
      slot_type [MAX_RUN-1:0]   slot;
   } run_type;

   function automatic logic signed [7:0] clamp8(input logic signed [7:0] v,
                                               input logic signed [7:0] lo,
                                               input logic signed [7:0] hi);
      logic signed [7:0] r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

   // tens digit of 0..79 by constant thresholds
   function automatic logic [2:0] tens_of(input logic [6:0] v);
      logic [2:0] t;
      t = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (v >= 7'(10 * i)) t = 3'(i);
      end
      return t;
   endfunction

   function automatic slot_type mk_slot(input logic chip, input logic [7:0] b,
                                        input logic st);
      slot_type s;
      s.chip            = chip;
      s.cmd_byte        = b;
      s.starts_transfer = st;
      return s;
   endfunction

endpackage
`default_nettype wire

### sv/apce_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apce_front
// Takes events, clamps settings, keeps the trims and flags, builds the run.
// ----------------------------------------------------------------------------
module apce_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire apce_pkg::req_type req_payload,
   input  wire logic             queue_full,
   output logic                  push,
   output apce_pkg::run_type     push_run
);
   import apce_pkg::*;

   logic signed [3:0] balance_ff, balance_in;
   logic signed [3:0] fader_ff, fader_in;
   logic signed [4:0] center_ff, center_in;
   logic signed [4:0] sub_ff, sub_in;
   logic              mute_ff, mute_in;
   logic              effect_ff, effect_in;
   logic              bypass_ff, bypass_in;

   logic              accept;
   logic              flag;
   logic signed [7:0] s;
   logic signed [7:0] c_tone, c_vol, c_gain, c_input, c_trim, c_level;
   logic [6:0]        vol_att;
   logic [2:0]        tens;
   logic [6:0]        units_w;
   logic [3:0]        tone_t, tone_code;
   logic [3:0]        bal_pos, bal_neg, fad_pos, fad_neg;
   logic [3:0]        att_fl, att_fr, att_rl, att_rr, att_ct, att_sb;
   logic [4:0]        ct_neg, sb_neg;
   logic [7:0]        fn_byte;
   logic [3:0]        in_code;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign s         = req_payload.setting;
   assign flag      = (req_payload.setting != 8'sd0);

   always_comb begin
      c_tone  = clamp8(s, -8'sd7, 8'sd7);
      c_vol   = clamp8(s, -8'sd79, 8'sd0);
      c_gain  = clamp8(s, 8'sd0, 8'sd1);
      c_input = clamp8(s, 8'sd0, 8'sd4);
      c_trim  = clamp8(s, -8'sd7, 8'sd7);
      c_level = clamp8(s, -8'sd15, 8'sd0);
   end

   // stored state with this event applied
   always_comb begin
      balance_in = balance_ff;
      fader_in   = fader_ff;
      center_in  = center_ff;
      sub_in     = sub_ff;
      mute_in    = mute_ff;
      effect_in  = effect_ff;
      bypass_in  = bypass_ff;
      case (req_payload.kind)
         KIND_FADER:   fader_in   = c_trim[3:0];
         KIND_BALANCE: balance_in = c_trim[3:0];
         KIND_CENTER:  center_in  = c_level[4:0];
         KIND_SUB:     sub_in     = c_level[4:0];
         KIND_MUTE:    mute_in    = flag;
         KIND_EFFECT:  effect_in  = flag;
         KIND_BYPASS:  bypass_in  = flag;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff <= '0;
         fader_ff   <= '0;
         center_ff  <= '0;
         sub_ff     <= '0;
         mute_ff    <= 1'b0;
         effect_ff  <= 1'b0;
         bypass_ff  <= 1'b0;
      end else if (accept) begin
         balance_ff <= balance_in;
         fader_ff   <= fader_in;
         center_ff  <= center_in;
         sub_ff     <= sub_in;
         mute_ff    <= mute_in;
         effect_ff  <= effect_in;
         bypass_ff  <= bypass_in;
      end
   end

   // byte fields
   always_comb begin
      vol_att = 7'(-c_vol);
      tens    = tens_of(vol_att);
      units_w = vol_att - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};

      tone_t    = c_tone[3:0];
      tone_code = (!tone_t[3] && tone_t != 4'd0) ? 4'd15 - tone_t : 4'd7 + tone_t;

      bal_pos = balance_in[3] ? 4'd0 : balance_in;
      bal_neg = balance_in[3] ? 4'(-balance_in) : 4'd0;
      fad_pos = fader_in[3] ? 4'd0 : fader_in;
      fad_neg = fader_in[3] ? 4'(-fader_in) : 4'd0;
      att_fl  = bal_pos + fad_neg;
      att_fr  = bal_neg + fad_neg;
      att_rl  = bal_pos + fad_pos;
      att_rr  = bal_neg + fad_pos;
      ct_neg  = 5'(-center_in);
      sb_neg  = 5'(-sub_in);
      att_ct  = ct_neg[3:0];
      att_sb  = sb_neg[3:0];

      fn_byte = CMD_FUNCTION | (mute_in ? FN_MUTE : 8'h00)
              | (effect_in ? 8'h00 : FN_EFFECT_OFF) | (bypass_in ? FN_BYPASS : 8'h00);
      in_code = INPUT_BASE - c_input[3:0];
   end

   always_comb begin
      push_run = '0;
      push     = accept;
      case (req_payload.kind)
         KIND_RESET: begin
            push_run.count   = RUN_CNT_W'(3);
            push_run.slot[0] = mk_slot(CHIP_MAIN, CMD_RESET_A, 1'b1);
            push_run.slot[1] = mk_slot(CHIP_MAIN, CMD_RESET_B, 1'b1);
            push_run.slot[2] = mk_slot(CHIP_MIXER, CMD_RESET_MIX, 1'b1);
         end
         KIND_VOLUME: begin
            push_run.count   = RUN_CNT_W'(2);
            push_run.slot[0] = mk_slot(CHIP_MAIN, CMD_TENS | {5'd0, tens}, 1'b1);
            push_run.slot[1] = mk_slot(CHIP_MAIN, CMD_UNITS | {4'd0, units_w[3:0]}, 1'b0);
         end
         KIND_BASS, KIND_MIDDLE, KIND_TREBLE: begin
            push_run.count   = RUN_CNT_W'(1);
            push_run.slot[0] = mk_slot(CHIP_MAIN,
                                       {req_payload.kind + TONE_NIB_OFS, tone_code}, 1'b1);
         end
         KIND_FADER, KIND_BALANCE, KIND_CENTER, KIND_SUB: begin
            push_run.count   = RUN_CNT_W'(6);
            push_run.slot[0] = mk_slot(CHIP_MAIN, {TRIM_FL, att_fl}, 1'b1);
            push_run.slot[1] = mk_slot(CHIP_MAIN, {TRIM_FR, att_fr}, 1'b0);
            push_run.slot[2] = mk_slot(CHIP_MAIN, {TRIM_CT, att_ct}, 1'b0);
            push_run.slot[3] = mk_slot(CHIP_MAIN, {TRIM_RL, att_rl}, 1'b0);
            push_run.slot[4] = mk_slot(CHIP_MAIN, {TRIM_RR, att_rr}, 1'b0);
            push_run.slot[5] = mk_slot(CHIP_MAIN, {TRIM_SB, att_sb}, 1'b0);
         end
         KIND_GAIN: begin
            push_run.count   = RUN_CNT_W'(1);
            push_run.slot[0] = mk_slot(CHIP_MIXER, CMD_GAIN | {7'd0, c_gain[0]}, 1'b1);
         end
         KIND_INPUT: begin
            push_run.count   = RUN_CNT_W'(1);
            push_run.slot[0] = mk_slot(CHIP_MIXER, CMD_INPUT | {4'd0, in_code}, 1'b1);
         end
         KIND_MUTE, KIND_EFFECT, KIND_BYPASS: begin
            push_run.count   = RUN_CNT_W'(1);
            push_run.slot[0] = mk_slot(CHIP_MAIN, fn_byte, 1'b1);
         end
         KIND_SURROUND: begin
            push_run.count   = RUN_CNT_W'(1);
            push_run.slot[0] = mk_slot(CHIP_MIXER, CMD_SURROUND | {7'd0, !flag}, 1'b1);
         end
         default: begin
            // unused kind: swallowed, no run
            push = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/apce_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apce_queue
// Short queue of pending runs between the front and the back.
// ----------------------------------------------------------------------------
module apce_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire apce_pkg::run_type                  push_run,
   input  wire logic                               pop,
   output logic                                    full,
   output logic                                    empty,
   output apce_pkg::run_type                       head_run,
   output logic [apce_pkg::QUEUE_LVL_W-1:0]        level
);
   import apce_pkg::*;

   run_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0]  level_ff, level_in;
   logic                    do_push, do_pop;

   assign full     = (level_ff == QUEUE_LVL_W'(QUEUE_DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign head_run = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) level_in = level_ff + 1'b1;
      if (!do_push && do_pop) level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_run;
   end

endmodule
`default_nettype wire

### sv/apce_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apce_back
// Walks the head run one byte per cycle into the output register while rsp_stall is low.
// ----------------------------------------------------------------------------
module apce_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire apce_pkg::run_type head_run,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output apce_pkg::rsp_type      rsp_payload
);
   import apce_pkg::*;

   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   rsp_type              data_ff, data_in;
   logic                 load;
   logic                 is_last;
   slot_type             cur;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;
   assign load        = !valid_ff || !rsp_stall;
   assign cur         = head_run.slot[idx_ff];
   assign is_last     = (RUN_CNT_W'(idx_ff) + RUN_CNT_W'(1)) == head_run.count;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !queue_empty;
         if (!queue_empty) begin
            data_in.chip            = cur.chip;
            data_in.cmd_byte        = cur.cmd_byte;
            data_in.starts_transfer = cur.starts_transfer;
            data_in.last            = is_last;
            if (is_last) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

### sv/audio_processor_command_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_processor_command_encoder_top
// Turns setting-change events into tagged command byte runs for two chips.
// ----------------------------------------------------------------------------
// Each accepted event yields a run of 1 to 6 command beats on the rsp channel
// (reset 3, volume 2, any trim 6, all others 1; kind 15 yields none). The
// front takes an event per cycle while the two-entry run queue has room; the
// back sequencer sends one beat per cycle from the head run while rsp_stall is
// low, and the first beat of a run is registered in the queue entry and then in
// the output register before it is presented. Trims and flags update when the
// event is taken.
module audio_processor_command_encoder_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire apce_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output apce_pkg::rsp_type      rsp_payload
);
   import apce_pkg::*;

   logic                   push, pop, q_full, q_empty;
   run_type                push_run, head_run;
   logic [QUEUE_LVL_W-1:0] q_level;

   apce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (q_full),
      .push        (push),
      .push_run    (push_run)
   );

   apce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_run (head_run),
      .level    (q_level)
   );

   apce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .head_run    (head_run),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      q_level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("run queue level out of range");

   // a run keeps going once its first beats have left
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.last) |=> rsp_valid)
      else $error("gap inside a run");

   // continuation beats only go to the main chip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.starts_transfer) |-> (rsp_payload.chip == CHIP_MAIN))
      else $error("continuation beat to mixer chip");

   // nothing is popped from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop while queue empty");

endmodule
`default_nettype wire
